@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

@@ sv/tccw_pkg.sv @@
package tccw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LIN_W  = 11;
   localparam int CELL_W = CHAR_W + ATTR_W;

   localparam int CW     = $clog2(COLUMNS);
   localparam int RW     = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   localparam int SCROLL_BASE = COLUMNS * (ROWS - 1);

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NULL  = 8'd0;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [LIN_W-1:0]  linear;
      logic              scrolled;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
   } result_type;

   function automatic logic [ADDR_W-1:0] cell_addr(logic [RW-1:0] row, logic [CW-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
   endfunction

endpackage

@@ sv/text_console_char_writer.sv @@
// A put, read or no-op request goes from acceptance through the execute and done states to
// the output register. A request that scrolls first copies the cells one row up, one cell a
// cycle, and then blanks the bottom row; a clear blanks every cell.
// One request is in work at a time, so a new request is taken only after the last one is through;
// the next is taken once the result sits in the output register, which waits while it is occupied.
// Reset is synchronous: after it the block blanks every cell of the screen before taking a
// request; attribute writes are taken at all times outside reset.
module text_console_char_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
                                    // scrolled[23], cell_char[31:24], cell_attr[39:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [tccw_pkg::ATTR_W-1:0] attr_ff;
   logic                        rsp_valid_ff;
   logic [39:0]                 rsp_data_ff;
   logic                        out_free;
   tccw_pkg::ram_req_type       ram_req;
   tccw_pkg::result_type        res;
   logic [tccw_pkg::CELL_W-1:0] rdata;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tccw_pkg::RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
         rsp_valid_ff <= res.valid || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_data_ff <= {res.cell_attr, res.cell_char, res.scrolled, res.linear, res.row, res.col};
      end
   end

   tccw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_code  (req_tdata[7:0]),
      .req_row   (req_tdata[12:8]),
      .req_col   (req_tdata[19:13]),
      .attr      (attr_ff),
      .out_free  (out_free),
      .rdata     (rdata),
      .ram_req   (ram_req),
      .res       (res)
   );

   tccw_cell_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

endmodule

@@ sv/tccw_cell_ram.sv @@
module tccw_cell_ram (
   input  logic                         clock,
   input  tccw_pkg::ram_req_type        ram_req,
   output logic [tccw_pkg::CELL_W-1:0]  rdata
);

   logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELLS];
   logic [tccw_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/tccw_seq.sv @@
`include "assert_macros.svh"

module tccw_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tccw_pkg::MODE_W-1:0]  req_mode,
   input  logic [tccw_pkg::CHAR_W-1:0]  req_code,
   input  logic [tccw_pkg::ROW_W-1:0]   req_row,
   input  logic [tccw_pkg::COL_W-1:0]   req_col,
   input  logic [tccw_pkg::ATTR_W-1:0]  attr,
   input  logic                         out_free,
   input  logic [tccw_pkg::CELL_W-1:0]  rdata,
   output tccw_pkg::ram_req_type        ram_req,
   output tccw_pkg::result_type         res
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_COPY  = 3'd3;
   localparam logic [2:0] S_BLANK = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [tccw_pkg::ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [tccw_pkg::ADDR_W-1:0]   wa_ff;
   logic [tccw_pkg::CW-1:0]       col_ff, col_in;
   logic [tccw_pkg::RW-1:0]       row_ff, row_in;
   logic                          scr_ff, scr_in;
   logic                          cell_ok_ff, cell_ok_in;
   logic [tccw_pkg::MODE_W-1:0]   mode_ff;
   logic [tccw_pkg::CHAR_W-1:0]   code_ff;
   logic [tccw_pkg::ROW_W-1:0]    rrow_ff;
   logic [tccw_pkg::COL_W-1:0]    rcol_ff;

   logic [tccw_pkg::CHAR_W-1:0]   code_eff;
   logic                          in_range;
   logic                          last_col;
   logic                          last_row;
   logic [tccw_pkg::CW-1:0]       bs_col, a_col;
   logic [tccw_pkg::RW-1:0]       bs_row, a_row;
   logic [tccw_pkg::ADDR_W-1:0]   addr;
   logic [tccw_pkg::CELL_W-1:0]   blank;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      code_eff = (code_ff == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : code_ff;
      in_range = (32'(rrow_ff) < 32'(tccw_pkg::ROWS)) && (32'(rcol_ff) < 32'(tccw_pkg::COLUMNS));
      last_col = (col_ff == tccw_pkg::CW'(tccw_pkg::COLUMNS - 1));
      last_row = (row_ff == tccw_pkg::RW'(tccw_pkg::ROWS - 1));
      blank    = {attr, tccw_pkg::CH_SPACE};

      if (col_ff != '0) begin
         bs_col = col_ff - tccw_pkg::CW'(1);
         bs_row = row_ff;
      end else if (row_ff != '0) begin
         bs_col = tccw_pkg::CW'(tccw_pkg::COLUMNS - 1);
         bs_row = row_ff - tccw_pkg::RW'(1);
      end else begin
         bs_col = '0;
         bs_row = '0;
      end

      // The one address unit serves reads, character writes and backspace blanking.
      if (mode_ff == tccw_pkg::MODE_READ) begin
         a_row = tccw_pkg::RW'(rrow_ff);
         a_col = tccw_pkg::CW'(rcol_ff);
      end else if (code_eff == tccw_pkg::CH_BS) begin
         a_row = bs_row;
         a_col = bs_col;
      end else begin
         a_row = row_ff;
         a_col = col_ff;
      end
      addr = tccw_pkg::cell_addr(a_row, a_col);

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      scr_in     = scr_ff;
      cell_ok_in = cell_ok_ff;
      ram_req    = '0;
      res        = '0;

      case (state_ff)
         S_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_ff;
            ram_req.wdata = {tccw_pkg::RESET_ATTR, tccw_pkg::CH_SPACE};
            if (cnt_ff == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + tccw_pkg::ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            scr_in     = 1'b0;
            cell_ok_in = 1'b0;
            state_in   = S_DONE;
            case (mode_ff)
               tccw_pkg::MODE_PUT: begin
                  if (code_eff == tccw_pkg::CH_NULL) begin
                     state_in = S_DONE;
                  end else if (code_eff == tccw_pkg::CH_NL) begin
                     col_in = '0;
                     if (last_row) begin
                        scr_in   = 1'b1;
                        cnt_in   = '0;
                        state_in = S_COPY;
                     end else begin
                        row_in = row_ff + tccw_pkg::RW'(1);
                     end
                  end else if (code_eff == tccw_pkg::CH_BS) begin
                     col_in        = bs_col;
                     row_in        = bs_row;
                     ram_req.we    = 1'b1;
                     ram_req.waddr = addr;
                     ram_req.wdata = blank;
                  end else begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = addr;
                     ram_req.wdata = {attr, code_eff};
                     if (last_col) begin
                        col_in = '0;
                        if (last_row) begin
                           scr_in   = 1'b1;
                           cnt_in   = '0;
                           state_in = S_COPY;
                        end else begin
                           row_in = row_ff + tccw_pkg::RW'(1);
                        end
                     end else begin
                        col_in = col_ff + tccw_pkg::CW'(1);
                     end
                  end
               end
               tccw_pkg::MODE_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  cnt_in   = '0;
                  state_in = S_BLANK;
               end
               tccw_pkg::MODE_READ: begin
                  ram_req.re    = in_range;
                  ram_req.raddr = addr;
                  cell_ok_in    = in_range;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_COPY: begin
            // Each cell is read one row below its target and written back in the following cycle.
            ram_req.re    = (cnt_ff != tccw_pkg::ADDR_W'(tccw_pkg::SCROLL_BASE));
            ram_req.raddr = cnt_ff + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
            ram_req.we    = (cnt_ff != '0);
            ram_req.waddr = wa_ff;
            ram_req.wdata = rdata;
            if (cnt_ff == tccw_pkg::ADDR_W'(tccw_pkg::SCROLL_BASE)) begin
               state_in = S_BLANK;
            end else begin
               cnt_in = cnt_ff + tccw_pkg::ADDR_W'(1);
            end
         end
         S_BLANK: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_ff;
            ram_req.wdata = blank;
            if (cnt_ff == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + tccw_pkg::ADDR_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               res.valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.col       = tccw_pkg::COL_W'(col_ff);
      res.row       = tccw_pkg::ROW_W'(row_ff);
      res.linear    = tccw_pkg::LIN_W'(tccw_pkg::cell_addr(row_ff, col_ff));
      res.scrolled  = scr_ff;
      res.cell_char = cell_ok_ff ? rdata[tccw_pkg::CHAR_W-1:0] : '0;
      res.cell_attr = cell_ok_ff ? rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         cnt_ff     <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         scr_ff     <= 1'b0;
         cell_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         scr_ff     <= scr_in;
         cell_ok_ff <= cell_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= cnt_ff;
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         code_ff <= req_code;
         rrow_ff <= req_row;
         rcol_ff <= req_col;
      end
   end

   `ASSERT_NEVER(a_copy_order, (state_ff == S_COPY) && ram_req.we && ram_req.re && (ram_req.waddr >= ram_req.raddr), "scroll copy writes at or beyond its read address")
   `ASSERT_IMPLY(a_res_slot, res.valid, out_free, "result issued while the output register is occupied")
   `ASSERT_NEXT(a_res_idle, res.valid, req_ready, "block not ready after delivering a result")
   `ASSERT_NEVER(a_col_range, 32'(col_ff) >= 32'(tccw_pkg::COLUMNS), "cursor column beyond the screen")

endmodule

@@ bench/text_console_checker.sv @@
`timescale 1ns / 100ps
module text_console_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
   input  logic [1:0]  req_tuser,   // mode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
                                    // scrolled[23], cell_char[31:24], cell_attr[39:32]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          mismatches,
   output int          pending
);

   // Declared from the top bit down, so that a cast of rsp_tdata lines up with the bus.
   typedef struct packed {
      logic [tccw_pkg::ATTR_W-1:0] attr;
      logic [tccw_pkg::CHAR_W-1:0] glyph;
      logic                        scrolled;
      logic [tccw_pkg::LIN_W-1:0]  linear;
      logic [tccw_pkg::ROW_W-1:0]  row;
      logic [tccw_pkg::COL_W-1:0]  col;
   } cursor_report_type;

   logic [tccw_pkg::CELL_W-1:0] screen_mem [tccw_pkg::CELLS];
   int                          col_pos;
   int                          row_pos;
   logic [tccw_pkg::ATTR_W-1:0] attr_reg;
   cursor_report_type           reports_due [$];
   int                          error_count = 0;

   function automatic logic [tccw_pkg::CELL_W-1:0] blank_glyph();
      return {attr_reg, tccw_pkg::CH_SPACE};
   endfunction

   function automatic void shift_rows_up();
      for (int i = 0; i < tccw_pkg::CELLS - tccw_pkg::COLUMNS; i++) begin
         screen_mem[i] = screen_mem[i + tccw_pkg::COLUMNS];
      end
      for (int i = tccw_pkg::CELLS - tccw_pkg::COLUMNS; i < tccw_pkg::CELLS; i++) begin
         screen_mem[i] = blank_glyph();
      end
   endfunction

   function automatic logic write_char(logic [tccw_pkg::CHAR_W-1:0] code);
      logic [tccw_pkg::CHAR_W-1:0] c;
      logic                        rolled;
      c      = (code == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : code;
      rolled = 1'b0;
      if (c == tccw_pkg::CH_NULL) begin
         return 1'b0;
      end
      if (c == tccw_pkg::CH_NL) begin
         if (row_pos < tccw_pkg::ROWS - 1) begin
            row_pos++;
         end else begin
            shift_rows_up();
            rolled = 1'b1;
         end
         col_pos = 0;
      end else if (c == tccw_pkg::CH_BS) begin
         if (col_pos == 0) begin
            if (row_pos > 0) begin
               col_pos = tccw_pkg::COLUMNS - 1;
               row_pos--;
            end
         end else begin
            col_pos--;
         end
         screen_mem[row_pos * tccw_pkg::COLUMNS + col_pos] = blank_glyph();
      end else begin
         screen_mem[row_pos * tccw_pkg::COLUMNS + col_pos] = {attr_reg, c};
         col_pos++;
         if (col_pos >= tccw_pkg::COLUMNS) begin
            col_pos = 0;
            if (row_pos >= tccw_pkg::ROWS - 1) begin
               shift_rows_up();
               rolled = 1'b1;
            end else begin
               row_pos++;
            end
         end
      end
      return rolled;
   endfunction

   function automatic cursor_report_type apply_request(logic [tccw_pkg::MODE_W-1:0] mode,
                                                       logic [tccw_pkg::CHAR_W-1:0] code,
                                                       logic [tccw_pkg::ROW_W-1:0] rrow,
                                                       logic [tccw_pkg::COL_W-1:0] rcol);
      cursor_report_type r;
      r = '0;
      case (mode)
         tccw_pkg::MODE_PUT: begin
            r.scrolled = write_char(code);
         end
         tccw_pkg::MODE_CLEAR: begin
            for (int i = 0; i < tccw_pkg::CELLS; i++) begin
               screen_mem[i] = blank_glyph();
            end
            col_pos = 0;
            row_pos = 0;
         end
         tccw_pkg::MODE_READ: begin
            if (rrow < tccw_pkg::ROWS && rcol < tccw_pkg::COLUMNS) begin
               {r.attr, r.glyph} = screen_mem[rrow * tccw_pkg::COLUMNS + rcol];
            end
         end
         default: begin
         end
      endcase
      r.col    = tccw_pkg::COL_W'(col_pos);
      r.row    = tccw_pkg::ROW_W'(row_pos);
      r.linear = tccw_pkg::LIN_W'(row_pos * tccw_pkg::COLUMNS + col_pos);
      return r;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      cursor_report_type seen;
      cursor_report_type want;
      if (reset) begin
         for (int i = 0; i < tccw_pkg::CELLS; i++) begin
            screen_mem[i] = {tccw_pkg::RESET_ATTR, tccw_pkg::CH_SPACE};
         end
         col_pos  = 0;
         row_pos  = 0;
         attr_reg = tccw_pkg::RESET_ATTR;
         reports_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = cursor_report_type'(rsp_tdata);
            if (reports_due.size() == 0) begin
               $error("result 0x%h arrived with no request outstanding", rsp_tdata);
               error_count++;
            end else begin
               want = reports_due.pop_front();
               check_field("cursor_col", want.col, seen.col);
               check_field("cursor_row", want.row, seen.row);
               check_field("cursor_linear", want.linear, seen.linear);
               check_field("scrolled", want.scrolled, seen.scrolled);
               check_field("cell_char", want.glyph, seen.glyph);
               check_field("cell_attr", want.attr, seen.attr);
            end
         end
         if (csr_valid && csr_ready) begin
            attr_reg = csr_data;
         end
         if (req_tvalid && req_tready) begin
            reports_due.push_back(apply_request(req_tuser, req_tdata[7:0],
                                                req_tdata[12:8], req_tdata[19:13]));
         end
      end
      mismatches <= error_count;
      pending    <= reports_due.size();
   end

endmodule

@@ bench/tb_text_console_char_writer.sv @@
`timescale 1ns / 100ps
module tb_text_console_char_writer;

   localparam logic [tccw_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int PHASE_ITEMS = 255;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [7:0]  csr_data   = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic        csr_ready;
   logic        steady     = 1'b0;
   int          mismatches;
   int          pending;
   int          sent       = 0;

   always #10 clock = ~clock;

   text_console_char_writer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   text_console_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 6);
   end

   task automatic send_request(input logic [tccw_pkg::MODE_W-1:0] mode,
                               input logic [tccw_pkg::CHAR_W-1:0] code,
                               input logic [tccw_pkg::ROW_W-1:0] row,
                               input logic [tccw_pkg::COL_W-1:0] col);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, col, row, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic put_char(input logic [tccw_pkg::CHAR_W-1:0] code);
      send_request(tccw_pkg::MODE_PUT, code, tccw_pkg::ROW_W'($urandom),
                   tccw_pkg::COL_W'($urandom));
   endtask

   task automatic read_at(input logic [tccw_pkg::ROW_W-1:0] row,
                          input logic [tccw_pkg::COL_W-1:0] col);
      send_request(tccw_pkg::MODE_READ, tccw_pkg::CHAR_W'($urandom), row, col);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_attribute(input logic [tccw_pkg::ATTR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [tccw_pkg::CHAR_W-1:0] text_code();
      case ($urandom_range(19))
         0:       return tccw_pkg::CH_TAB;
         1:       return tccw_pkg::CH_BS;
         2:       return tccw_pkg::CH_NULL;
         default: return tccw_pkg::CHAR_W'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic random_traffic(input int quota);
      int first;
      int kind;
      int len;
      first = sent;
      while (sent - first < quota) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 8);
            repeat (len) put_char(text_code());
            if ($urandom_range(9) != 0) begin
               put_char(tccw_pkg::CH_NL);
            end
         end else if (kind < 82) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(9) == 0) begin
                  read_at(tccw_pkg::ROW_W'($urandom), tccw_pkg::COL_W'($urandom));
               end else begin
                  read_at(tccw_pkg::ROW_W'($urandom_range(0, tccw_pkg::ROWS - 1)),
                          tccw_pkg::COL_W'(($urandom_range(3) == 0)
                                           ? $urandom_range(0, tccw_pkg::COLUMNS - 1)
                                           : $urandom_range(0, 15)));
               end
            end
         end else if (kind < 91) begin
            repeat ($urandom_range(1, 4)) put_char(tccw_pkg::CH_BS);
         end else if (kind < 92) begin
            send_request(tccw_pkg::MODE_CLEAR, tccw_pkg::CHAR_W'($urandom),
                         tccw_pkg::ROW_W'($urandom), tccw_pkg::COL_W'($urandom));
         end else begin
            case ($urandom_range(2))
               0:       send_request(tccw_pkg::MODE_PUT, tccw_pkg::CHAR_W'($urandom),
                                     tccw_pkg::ROW_W'($urandom), tccw_pkg::COL_W'($urandom));
               1:       send_request(tccw_pkg::MODE_READ, tccw_pkg::CHAR_W'($urandom),
                                     tccw_pkg::ROW_W'($urandom), tccw_pkg::COL_W'($urandom));
               default: send_request(MODE_SPARE, tccw_pkg::CHAR_W'($urandom),
                                     tccw_pkg::ROW_W'($urandom), tccw_pkg::COL_W'($urandom));
            endcase
         end
      end
   endtask

   initial begin : stimulus
      logic [tccw_pkg::ATTR_W-1:0] attr_plan [6];
      attr_plan[0] = 8'h00;
      attr_plan[1] = 8'hFF;
      attr_plan[2] = tccw_pkg::ATTR_W'($urandom);
      attr_plan[3] = 8'h80;
      attr_plan[4] = tccw_pkg::ATTR_W'($urandom);
      attr_plan[5] = 8'h01;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      read_at(5'd0, 7'd0);
      read_at(5'd24, 7'd79);
      read_at(5'd31, 7'd127);
      read_at(5'd25, 7'd0);
      read_at(5'd0, 7'd80);
      put_char(tccw_pkg::CH_NULL);
      put_char(tccw_pkg::CH_BS);
      put_char(8'h41);
      put_char(8'hFF);
      put_char(tccw_pkg::CH_TAB);
      put_char(tccw_pkg::CH_BS);
      read_at(5'd0, 7'd0);
      read_at(5'd0, 7'd1);
      put_char(tccw_pkg::CH_NL);
      put_char(tccw_pkg::CH_BS);
      put_char(8'h5A);
      read_at(5'd0, 7'd79);
      send_request(MODE_SPARE, 8'hFF, 5'h1F, 7'h7F);
      send_request(tccw_pkg::MODE_CLEAR, 8'h00, 5'h00, 7'h00);
      read_at(5'd0, 7'd0);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         write_attribute(attr_plan[phase]);
         steady <= (phase == 2);
         random_traffic(PHASE_ITEMS);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("text_console_char_writer verification clean");
      end else begin
         $display("text_console_char_writer verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000_000;
      $display("text_console_char_writer verification failed");
      $finish;
   end

endmodule

@@ text_console_char_writer.f @@
+incdir+sv
sv/tccw_pkg.sv
sv/tccw_cell_ram.sv
sv/tccw_seq.sv
sv/text_console_char_writer.sv
bench/text_console_checker.sv
bench/tb_text_console_char_writer.sv
